// ----- rtl/core/convex_hull_graham_scan_defines.svh -----
// ----------------------------------------------------------------------------
// convex_hull_graham_scan_defines
// assertion macros shared by the hull block
// ----------------------------------------------------------------------------
`ifndef CONVEX_HULL_GRAHAM_SCAN_DEFINES_SVH
`define CONVEX_HULL_GRAHAM_SCAN_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define CVH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CVH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cvh_pkg.sv -----
// ----------------------------------------------------------------------------
// cvh_pkg
// shared types of the convex hull block
// ----------------------------------------------------------------------------
package cvh_pkg;

    // side flags that travel with a hull vertex
    typedef struct packed {
        logic last;
        logic ovf;
    } hull_flags_t;

endpackage

// ----- rtl/core/convex_hull_graham_scan.sv -----
// ----------------------------------------------------------------------------
// convex_hull_graham_scan
// convex hull of a loaded point set by graham scan
// ----------------------------------------------------------------------------
// Input beats on s_* carry one point each (x low, y high in s_tdata); s_tlast
// marks the final point of a set and starts the hull computation. Points past
// MAX_POINTS are dropped and flagged on m_tuser of every vertex of that set.
// Output beats on m_* carry the hull vertices counterclockwise from the
// lowest (then leftmost) point; m_tlast marks the final vertex.
// Loading accepts one point per cycle. After the last point come the pivot
// search, the insertion sort through the single read port of the point ram
// and the shared pair of product registers, then the scan with its pushes and
// turn tests, then the vertices out. Throughput is set by the sort, O(n^2)
// compares.
// s_tready is high only while loading; one set is worked on at a time.
// A stalled receiver holds the vertex in the output register until taken.
// Reset (aresetn low, synchronous) empties the set and drops any output.
// ----------------------------------------------------------------------------
`include "convex_hull_graham_scan_defines.svh"

module convex_hull_graham_scan
    import cvh_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // pt_x, pt_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // hull_x, hull_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    output logic m_tlast,
    // overflowed
    output logic m_tuser
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PT_W  = 2 * COORD_BITS;
    localparam int TD_W  = ((PT_W + 7) / 8) * 8;
    localparam int D_W   = COORD_BITS + 1;
    localparam int P_W   = 2 * D_W;
    localparam int S_W   = P_W + 1;

    typedef enum logic [4:0] {
        ST_LOAD, ST_PIV_RD, ST_PIV_CHK, ST_SWAP0, ST_SWAP1,
        ST_SRT_KEY, ST_SRT_KEYW, ST_SRT_RD, ST_SRT_OPND, ST_SRT_DEC, ST_SRT_INS,
        ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4,
        ST_SCN_RD, ST_SCN_GET, ST_SCN_TEST, ST_SCN_DEC, ST_SCN_POPW, ST_SCN_PUSH,
        ST_OUT_RD, ST_OUT_LD, ST_OUT_HOLD
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        cnt_reg, i_reg, k_reg, stk_reg;
    logic                    ovf_reg, scan_reg;
    logic [IDX_W-1:0]        u_reg;
    logic [PT_W-1:0]         best_reg, p0_reg, key_reg, b_reg, t0_reg, t1_reg, c_reg;
    logic signed [D_W-1:0]   ux_reg, uy_reg, vx_reg, vy_reg;
    logic signed [P_W-1:0]   p1_reg, p2_reg;
    logic signed [S_W-1:0]   turn_reg, da_reg, db_reg;
    logic                    m_tvalid_reg;
    logic [PT_W-1:0]         m_data_reg;
    hull_flags_t             flags_reg;

    logic                    pm_we, sk_we;
    logic [IDX_W-1:0]        pm_waddr, pm_raddr, sk_waddr, sk_raddr;
    logic [PT_W-1:0]         pm_wdata, pm_rdata, sk_rdata;
    logic [CNT_W-1:0]        i_inc;
    logic                    i_done, lower, a_on, b_on, goes_first;

    function automatic logic signed [D_W-1:0] xdiff(input logic [PT_W-1:0] a,
                                                    input logic [PT_W-1:0] b);
        xdiff = $signed({a[COORD_BITS-1], a[COORD_BITS-1:0]})
              - $signed({b[COORD_BITS-1], b[COORD_BITS-1:0]});
    endfunction

    function automatic logic signed [D_W-1:0] ydiff(input logic [PT_W-1:0] a,
                                                    input logic [PT_W-1:0] b);
        ydiff = $signed({a[PT_W-1], a[PT_W-1:COORD_BITS]})
              - $signed({b[PT_W-1], b[PT_W-1:COORD_BITS]});
    endfunction

    cvh_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
        .clk(aclk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr), .rdata(pm_rdata)
    );

    cvh_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_stack_ram (
        .clk(aclk), .we(sk_we), .waddr(sk_waddr), .wdata(c_reg),
        .raddr(sk_raddr), .rdata(sk_rdata)
    );

    assign i_inc  = i_reg + CNT_W'(1);
    assign i_done = (i_inc == cnt_reg);

    // lowest point, leftmost on ties
    assign lower = ($signed(pm_rdata[PT_W-1:COORD_BITS]) <
                    $signed(best_reg[PT_W-1:COORD_BITS])) ||
                   ((pm_rdata[PT_W-1:COORD_BITS] == best_reg[PT_W-1:COORD_BITS]) &&
                    ($signed(pm_rdata[COORD_BITS-1:0]) <
                     $signed(best_reg[COORD_BITS-1:0])));

    // angular order about the pivot, nearer first when collinear
    assign a_on = (key_reg == best_reg);
    assign b_on = (b_reg == best_reg);
    assign goes_first = (a_on || b_on) ? (a_on && !b_on)
                      : ((turn_reg > 0) || ((turn_reg == 0) && (da_reg < db_reg)));

    always_comb begin
        pm_we    = 1'b0;
        pm_waddr = cnt_reg[IDX_W-1:0];
        pm_wdata = s_tdata[PT_W-1:0];
        pm_raddr = i_reg[IDX_W-1:0];
        sk_we    = 1'b0;
        sk_waddr = stk_reg[IDX_W-1:0];
        sk_raddr = i_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_LOAD: begin
                pm_we = s_tvalid && (cnt_reg < CNT_W'(MAX_POINTS));
            end
            ST_SWAP0: begin
                pm_we    = 1'b1;
                pm_waddr = '0;
                pm_wdata = best_reg;
            end
            ST_SWAP1: begin
                pm_we    = 1'b1;
                pm_waddr = u_reg;
                pm_wdata = p0_reg;
            end
            ST_SRT_RD: begin
                pm_raddr = IDX_W'(k_reg - CNT_W'(1));
            end
            ST_SRT_DEC: begin
                pm_we    = goes_first;
                pm_waddr = k_reg[IDX_W-1:0];
                pm_wdata = b_reg;
            end
            ST_SRT_INS: begin
                pm_we    = 1'b1;
                pm_waddr = k_reg[IDX_W-1:0];
                pm_wdata = key_reg;
            end
            ST_SCN_DEC: begin
                sk_raddr = IDX_W'(stk_reg - CNT_W'(3));
            end
            ST_SCN_PUSH: begin
                sk_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            stk_reg      <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_tvalid) begin
                        if (cnt_reg < CNT_W'(MAX_POINTS)) begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            i_reg     <= '0;
                            state_reg <= ST_PIV_RD;
                        end
                    end
                end
                ST_PIV_RD: state_reg <= ST_PIV_CHK;
                ST_PIV_CHK: begin
                    if (i_reg == '0) begin
                        best_reg <= pm_rdata;
                        p0_reg   <= pm_rdata;
                        u_reg    <= '0;
                    end else if (lower) begin
                        best_reg <= pm_rdata;
                        u_reg    <= i_reg[IDX_W-1:0];
                    end
                    i_reg     <= i_inc;
                    state_reg <= i_done ? ST_SWAP0 : ST_PIV_RD;
                end
                ST_SWAP0: state_reg <= ST_SWAP1;
                ST_SWAP1: begin
                    if (cnt_reg < CNT_W'(3)) begin
                        i_reg     <= '0;
                        stk_reg   <= '0;
                        scan_reg  <= 1'b1;
                        state_reg <= ST_SCN_RD;
                    end else begin
                        i_reg     <= CNT_W'(2);
                        scan_reg  <= 1'b0;
                        state_reg <= ST_SRT_KEY;
                    end
                end
                ST_SRT_KEY: state_reg <= ST_SRT_KEYW;
                ST_SRT_KEYW: begin
                    key_reg   <= pm_rdata;
                    ux_reg    <= xdiff(pm_rdata, best_reg);
                    uy_reg    <= ydiff(pm_rdata, best_reg);
                    k_reg     <= i_reg;
                    state_reg <= ST_SRT_RD;
                end
                ST_SRT_RD: begin
                    state_reg <= (k_reg > CNT_W'(1)) ? ST_SRT_OPND : ST_SRT_INS;
                end
                ST_SRT_OPND: begin
                    b_reg     <= pm_rdata;
                    vx_reg    <= xdiff(pm_rdata, best_reg);
                    vy_reg    <= ydiff(pm_rdata, best_reg);
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    p1_reg    <= ux_reg * vy_reg;
                    p2_reg    <= uy_reg * vx_reg;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    turn_reg  <= $signed({p1_reg[P_W-1], p1_reg})
                               - $signed({p2_reg[P_W-1], p2_reg});
                    p1_reg    <= ux_reg * ux_reg;
                    p2_reg    <= uy_reg * uy_reg;
                    state_reg <= scan_reg ? ST_SCN_DEC : ST_MUL3;
                end
                ST_MUL3: begin
                    da_reg    <= $signed({1'b0, p1_reg}) + $signed({1'b0, p2_reg});
                    p1_reg    <= vx_reg * vx_reg;
                    p2_reg    <= vy_reg * vy_reg;
                    state_reg <= ST_MUL4;
                end
                ST_MUL4: begin
                    db_reg    <= $signed({1'b0, p1_reg}) + $signed({1'b0, p2_reg});
                    state_reg <= ST_SRT_DEC;
                end
                ST_SRT_DEC: begin
                    if (goes_first) begin
                        k_reg     <= k_reg - CNT_W'(1);
                        state_reg <= ST_SRT_RD;
                    end else begin
                        state_reg <= ST_SRT_INS;
                    end
                end
                ST_SRT_INS: begin
                    if (i_done) begin
                        i_reg     <= '0;
                        stk_reg   <= '0;
                        scan_reg  <= 1'b1;
                        state_reg <= ST_SCN_RD;
                    end else begin
                        i_reg     <= i_inc;
                        state_reg <= ST_SRT_KEY;
                    end
                end
                ST_SCN_RD: state_reg <= ST_SCN_GET;
                ST_SCN_GET: begin
                    c_reg     <= pm_rdata;
                    state_reg <= ST_SCN_TEST;
                end
                ST_SCN_TEST: begin
                    ux_reg    <= xdiff(t1_reg, t0_reg);
                    uy_reg    <= ydiff(t1_reg, t0_reg);
                    vx_reg    <= xdiff(c_reg, t0_reg);
                    vy_reg    <= ydiff(c_reg, t0_reg);
                    state_reg <= (stk_reg > CNT_W'(1)) ? ST_MUL1 : ST_SCN_PUSH;
                end
                ST_SCN_DEC: begin
                    if (turn_reg <= 0) begin
                        // pop; refill second-from-top from the stack ram
                        stk_reg   <= stk_reg - CNT_W'(1);
                        t1_reg    <= t0_reg;
                        state_reg <= (stk_reg > CNT_W'(2)) ? ST_SCN_POPW : ST_SCN_TEST;
                    end else begin
                        state_reg <= ST_SCN_PUSH;
                    end
                end
                ST_SCN_POPW: begin
                    t0_reg    <= sk_rdata;
                    state_reg <= ST_SCN_TEST;
                end
                ST_SCN_PUSH: begin
                    t0_reg  <= t1_reg;
                    t1_reg  <= c_reg;
                    stk_reg <= stk_reg + CNT_W'(1);
                    if (i_done) begin
                        i_reg     <= '0;
                        state_reg <= ST_OUT_RD;
                    end else begin
                        i_reg     <= i_inc;
                        state_reg <= ST_SCN_RD;
                    end
                end
                ST_OUT_RD: state_reg <= ST_OUT_LD;
                ST_OUT_LD: begin
                    m_data_reg     <= sk_rdata;
                    flags_reg.last <= (i_inc == stk_reg);
                    flags_reg.ovf  <= ovf_reg;
                    m_tvalid_reg   <= 1'b1;
                    state_reg      <= ST_OUT_HOLD;
                end
                ST_OUT_HOLD: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (flags_reg.last) begin
                            cnt_reg   <= '0;
                            stk_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_LOAD;
                        end else begin
                            i_reg     <= i_inc;
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TD_W'(m_data_reg);
    assign m_tlast  = flags_reg.last;
    assign m_tuser  = flags_reg.ovf;

    `CVH_ASSERT_IMPL(a_load_excl_out, s_tready, !m_tvalid, "input open while a vertex is out")
    `CVH_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(MAX_POINTS), "point count past capacity")
    `CVH_ASSERT_IMPL(a_stack_bound, 1'b1, stk_reg <= cnt_reg, "hull stack deeper than set")
    `CVH_ASSERT_NEXT(a_set_clear, m_tvalid && m_tready && m_tlast, cnt_reg == '0 && !ovf_reg,
                     "set not cleared after final vertex")

endmodule

// ----- rtl/core/cvh_ram.sv -----
// ----------------------------------------------------------------------------
// cvh_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cvh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
